// File: design/cbls_pkg.sv
// Shared types, constants and scramble functions for the challenge buffer scrambler.
`default_nettype none
package cbls_pkg;

    localparam int DEF_BUFFER_BYTES = 512;
    localparam int CHUNK_BYTES      = 8;
    localparam int DATA_W           = 64;
    localparam int WORD_W           = 32;
    localparam int LFSR_W           = 16;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic rd_last;
        logic start;
    } cbls_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic rd_room;
        logic busy;
    } cbls_sts_t;

    typedef struct packed {
        logic [LFSR_W-1:0] lfsr;
        logic [DATA_W-1:0] chunk;
    } cbls_scr_t;

    // Collect bit 0 of each byte, byte 0 ending up in the top position
    function automatic logic [CHUNK_BYTES-1:0] byte_lsbs(input logic [DATA_W-1:0] chunk);
        logic [CHUNK_BYTES-1:0] bits;
        bits = '0;
        for (int k = 0; k < CHUNK_BYTES; k++) begin
            bits[CHUNK_BYTES-1-k] = chunk[8*k];
        end
        return bits;
    endfunction

    // Shift the low word right and the high word left by one bit
    function automatic logic [DATA_W-1:0] shift_words(input logic [DATA_W-1:0] chunk);
        logic [WORD_W-1:0] even_w;
        logic [WORD_W-1:0] odd_w;
        even_w = chunk[WORD_W-1:0];
        odd_w  = chunk[DATA_W-1:WORD_W];
        return {odd_w[WORD_W-2:0], 1'b0, 1'b0, even_w[WORD_W-1:1]};
    endfunction

    // Shift the words, then run the shift register once per byte, replacing each byte's bit 0
    function automatic cbls_scr_t scramble(input logic [DATA_W-1:0] chunk,
                                           input logic [LFSR_W-1:0] lfsr);
        cbls_scr_t res;
        logic [LFSR_W-1:0] s;
        logic [DATA_W-1:0] c;
        s = lfsr;
        c = shift_words(chunk);
        for (int k = 0; k < CHUNK_BYTES; k++) begin
            s = {s[LFSR_W-2:0], s[LFSR_W-1] ^ s[LFSR_W-2]};
            c[8*k] = s[LFSR_W-1];
        end
        res.lfsr  = s;
        res.chunk = c;
        return res;
    endfunction

endpackage
`default_nettype wire

// File: design/cbls_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module cbls_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port; read data holds without rd_en
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// File: design/cbls_dpath.sv
// Datapath: challenge store, seed capture, shift register and output stages.
`default_nettype none
module cbls_dpath #(
    parameter int BUFFER_BYTES = cbls_pkg::DEF_BUFFER_BYTES
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire cbls_pkg::cbls_cmd_t                    cmd,
    input  wire logic [$clog2(BUFFER_BYTES/8)-1:0]      addr,
    output cbls_pkg::cbls_sts_t                         sts,
    input  wire logic [cbls_pkg::DATA_W-1:0]            s_chunk_in,
    output logic                                        m_valid,
    input  wire logic                                   m_ready,
    output logic [cbls_pkg::DATA_W-1:0]                 m_chunk_out,
    output logic                                        m_last_chunk
);
    import cbls_pkg::*;

    localparam int CHUNK_COUNT = BUFFER_BYTES / CHUNK_BYTES;

    logic [DATA_W-1:0] rd_data;
    logic              s1_valid_reg, s1_valid_next;
    logic              s1_last_reg;
    logic              s2_valid_reg, s2_valid_next;
    logic [DATA_W-1:0] s2_data_reg;
    logic              s2_last_reg;
    logic [LFSR_W-1:0] seed_reg, seed_next;
    logic [LFSR_W-1:0] lfsr_reg;
    logic              move;
    cbls_scr_t         scr;

    cbls_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CHUNK_COUNT)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (cmd.wr_en),
        .wr_addr (addr),
        .wr_data (s_chunk_in),
        .rd_en   (cmd.rd_en),
        .rd_addr (addr),
        .rd_data (rd_data)
    );

    // Keep the byte lsbs of the most recent chunks; the last two chunks seed the register
    assign seed_next = {seed_reg[LFSR_W-CHUNK_BYTES-1:0], byte_lsbs(s_chunk_in)};

    // Advance the read stage into the output register when it is free or being emptied
    assign move          = s1_valid_reg && (!s2_valid_reg || m_ready);
    assign s1_valid_next = cmd.rd_en || (s1_valid_reg && !move);
    assign s2_valid_next = move || (s2_valid_reg && !m_ready);
    assign scr           = scramble(rd_data, lfsr_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            seed_reg <= seed_next;
        end
        if (cmd.rd_en) begin
            s1_last_reg <= cmd.rd_last;
        end
        if (cmd.start) begin
            lfsr_reg <= seed_next;
        end else if (move) begin
            lfsr_reg <= scr.lfsr;
        end
        if (move) begin
            s2_data_reg <= scr.chunk;
            s2_last_reg <= s1_last_reg;
        end
    end

    assign sts.rd_room   = !s1_valid_reg || move;
    assign sts.busy      = s1_valid_reg || s2_valid_reg;
    assign m_valid       = s2_valid_reg;
    assign m_chunk_out   = s2_data_reg;
    assign m_last_chunk  = s2_last_reg;

endmodule
`default_nettype wire

// File: design/cbls_ctrl.sv
// Controller: load, emit and drain sequencing with the shared chunk counter.
`default_nettype none
module cbls_ctrl #(
    parameter int BUFFER_BYTES = cbls_pkg::DEF_BUFFER_BYTES
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    output cbls_pkg::cbls_cmd_t                    cmd,
    output logic [$clog2(BUFFER_BYTES/8)-1:0]      addr,
    input  wire cbls_pkg::cbls_sts_t               sts
);
    import cbls_pkg::*;

    localparam int CHUNK_COUNT = BUFFER_BYTES / CHUNK_BYTES;
    localparam int CW          = $clog2(CHUNK_COUNT);
    localparam logic [CW-1:0] LAST_IDX = CW'(CHUNK_COUNT - 1);

    localparam logic [1:0] ST_LOAD  = 2'd0;
    localparam logic [1:0] ST_EMIT  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          at_last;

    assign at_last = (cnt_reg == LAST_IDX);

    // Sequence the load, emit and drain phases
    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        cmd         = '0;
        s_ready     = 1'b0;
        case (state_reg)
            ST_LOAD: begin
                s_ready   = 1'b1;
                cmd.wr_en = s_valid;
                if (s_valid) begin
                    if (at_last) begin
                        cnt_next   = '0;
                        cmd.start  = 1'b1;
                        state_next = ST_EMIT;
                    end else begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            ST_EMIT: begin
                cmd.rd_en   = sts.rd_room;
                cmd.rd_last = at_last;
                if (sts.rd_room) begin
                    if (at_last) begin
                        cnt_next   = '0;
                        state_next = ST_DRAIN;
                    end else begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            ST_DRAIN: begin
                if (!sts.busy) begin
                    state_next = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
                cnt_next   = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign addr = cnt_reg;

    // Reads are issued only when the read stage can take the data
    a_rd_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd_en |-> sts.rd_room)
        else $error("read issued without room in the read stage");

    // The pipeline is empty whenever a new challenge is being loaded
    a_load_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOAD) |-> !sts.busy)
        else $error("loading while results are still in flight");

    // Completing a challenge starts emission with the counter cleared
    a_start_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start |=> (state_reg == ST_EMIT) && (cnt_reg == '0))
        else $error("emission did not start after the last chunk");

    // The final read leads to the drain phase
    a_last_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.rd_en && cmd.rd_last) |=> (state_reg == ST_DRAIN))
        else $error("last read did not enter drain");

endmodule
`default_nettype wire

// File: design/challenge_buffer_lfsr_scrambler_top.sv
// Top level of the challenge buffer scrambler: controller plus datapath.
//
// Usage:
//   The s_ channel (s_valid/s_ready/s_chunk_in) takes the challenge as
//   BUFFER_BYTES/8 chunks of eight bytes, byte k in bits 8k+7:8k, in buffer
//   order, one item per cycle while s_ready is high.
//   After the last chunk is accepted, s_ready drops and the m_ channel
//   (m_valid/m_ready/m_chunk_out/m_last_chunk) delivers the BUFFER_BYTES/8
//   scrambled chunks in the same order, m_last_chunk marking the final one.
//   The first response chunk passes from the emit state through the RAM read
//   register to the output register after the last input chunk is accepted;
//   the rest follow one per cycle while m_ready stays high.
//   The single read port of the challenge RAM and one scramble step per cycle
//   set the emit rate.
//   When m_ready is low the output and read stages hold and reads stop; no
//   item is lost. s_ready returns high once the whole response is delivered.
//   Reset (aresetn low, synchronous) empties the pipeline and returns to the
//   loading phase at chunk zero; no clearing pass is needed.
`default_nettype none
module challenge_buffer_lfsr_scrambler_top #(
    parameter int BUFFER_BYTES = cbls_pkg::DEF_BUFFER_BYTES
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [cbls_pkg::DATA_W-1:0]   s_chunk_in,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [cbls_pkg::DATA_W-1:0]        m_chunk_out,
    output logic                               m_last_chunk
);
    import cbls_pkg::*;

    localparam int CW = $clog2(BUFFER_BYTES / CHUNK_BYTES);

    cbls_cmd_t     cmd;
    cbls_sts_t     sts;
    logic [CW-1:0] addr;

    cbls_ctrl #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .addr    (addr),
        .sts     (sts)
    );

    cbls_dpath #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_dpath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .addr         (addr),
        .sts          (sts),
        .s_chunk_in   (s_chunk_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_chunk_out  (m_chunk_out),
        .m_last_chunk (m_last_chunk)
    );

endmodule
`default_nettype wire
